[rtl/core/dkec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dkec_pkg;

  // Default depth of the result queue; it must hold at least two records.
  localparam int unsigned ResDepthDef = 4;

  typedef enum logic [2:0] {
    EV_START   = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_SECOND  = 3'd3,
    EV_TENTH   = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    CFG_ENTRY_MODE  = 3'd0,
    CFG_MAX_LENGTH  = 3'd1,
    CFG_END_CODE    = 3'd2,
    CFG_TIMEOUT_SEC = 3'd3,
    CFG_TAP_DELAY   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_RAW   = 2'd0,
    MODE_DIGIT = 2'd1,
    MODE_TAP   = 2'd2,
    MODE_ALT   = 2'd3
  } entry_mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_HOOK    = 2'd2,
    ST_LENGTH  = 2'd3
  } end_status_e;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [3:0] LastTableCode = 4'd12;
  localparam logic [7:0] CharDash      = 8'h2D;

  localparam logic [7:0] DigitTab [13] = '{
    8'h2D, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h30, 8'h2A, 8'h23
  };

  // Four letters per key, indexed by key code times four plus tap count.
  localparam logic [7:0] TapTab [52] = '{
    8'h2D, 8'h2D, 8'h2D, 8'h2D, 8'h71, 8'hF1, 8'h7A, 8'h31,
    8'h61, 8'h62, 8'h63, 8'h32, 8'h64, 8'h65, 8'h66, 8'h33,
    8'h67, 8'h68, 8'h69, 8'h34, 8'h6A, 8'h6B, 8'h6C, 8'h35,
    8'h6D, 8'h6E, 8'h6F, 8'h36, 8'h70, 8'h72, 8'h73, 8'h37,
    8'h74, 8'h75, 8'h76, 8'h38, 8'h77, 8'h78, 8'h79, 8'h39,
    8'h20, 8'h2D, 8'h5F, 8'h30, 8'h2A, 8'h2E, 8'h2C, 8'h3A,
    8'h23, 8'h23, 8'h23, 8'h23
  };

  typedef struct packed {
    logic [1:0] entry_mode;
    logic [7:0] max_length;
    logic [3:0] end_code;
    logic [7:0] timeout_seconds;
    logic [3:0] tap_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_value;
    logic [7:0] position;
    logic [1:0] status;
    logic       last;
  } res_t;

  // Records produced by one word: count is 0, 1 or 2, first goes out first.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

`default_nettype wire

[rtl/core/dkec_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module dkec_core
  import dkec_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       accept_i,
  input  wire logic [2:0] ev_i,
  input  wire logic [3:0] key_code_i,
  input  wire logic       on_hook_i,
  output push_t           push_o
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_WAIT    = 5'b00010,
    PH_HELD    = 5'b00100,
    PH_TAPHELD = 5'b01000,
    PH_TAPWAIT = 5'b10000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  secs_q, secs_d;
  logic [3:0]  tt_q, tt_d;
  logic [1:0]  tc_q, tc_d;
  logic [3:0]  hc_q, hc_d;
  logic [7:0]  sc_q, sc_d;

  logic        ch_v, end_v;
  logic [1:0]  end_st;
  logic [7:0]  ch_pos;
  logic [7:0]  held_char;

  always_comb begin
    if (hc_q == cfg_i.end_code || cfg_i.entry_mode == MODE_RAW ||
        cfg_i.entry_mode == MODE_ALT) begin
      held_char = {4'd0, hc_q};
    end else if (hc_q > LastTableCode) begin
      held_char = CharDash;
    end else if (cfg_i.entry_mode == MODE_DIGIT) begin
      held_char = DigitTab[hc_q];
    end else begin
      held_char = TapTab[{hc_q, tc_q}];
    end
  end

  always_comb begin
    logic       do_store;
    logic       do_wait;
    logic [7:0] secs_n;
    logic [3:0] tt_n;
    logic [8:0] nc;

    phase_d  = phase_q;
    secs_d   = secs_q;
    tt_d     = tt_q;
    tc_d     = tc_q;
    hc_d     = hc_q;
    sc_d     = sc_q;
    ch_v     = 1'b0;
    ch_pos   = sc_q;
    end_v    = 1'b0;
    end_st   = ST_OK;
    do_store = 1'b0;
    do_wait  = 1'b0;
    secs_n   = (ev_i == EV_SECOND && secs_q != 8'd0) ? secs_q - 8'd1 : secs_q;
    tt_n     = (tt_q != 4'd0) ? tt_q - 4'd1 : tt_q;
    nc       = {1'b0, sc_q} + 9'd1;

    if (ev_i == EV_START) begin
      sc_d    = 8'd0;
      tc_d    = 2'd0;
      tt_d    = 4'd0;
      hc_d    = 4'd0;
      do_wait = 1'b1;
    end else if (ev_i <= EV_TENTH) begin
      unique case (phase_q)
        PH_WAIT: begin
          secs_d = secs_n;
          if (secs_n == 8'd0) begin
            end_v  = 1'b1;
            end_st = ST_TIMEOUT;
          end else if (on_hook_i) begin
            end_v  = 1'b1;
            end_st = ST_HOOK;
          end else if (ev_i == EV_PRESS) begin
            hc_d    = key_code_i;
            tc_d    = 2'd0;
            phase_d = (cfg_i.entry_mode == MODE_TAP) ? PH_TAPHELD : PH_HELD;
          end
        end
        PH_HELD: begin
          if (ev_i == EV_RELEASE || on_hook_i) do_store = 1'b1;
        end
        PH_TAPHELD: begin
          if (ev_i == EV_RELEASE || on_hook_i) begin
            if (cfg_i.tap_delay_ticks == 4'd0) begin
              do_store = 1'b1;
            end else begin
              phase_d = PH_TAPWAIT;
              tt_d    = cfg_i.tap_delay_ticks;
            end
          end
        end
        PH_TAPWAIT: begin
          if (ev_i == EV_TENTH) begin
            tt_d = tt_n;
            if (tt_n == 4'd0) do_store = 1'b1;
          end else if (ev_i == EV_PRESS) begin
            if (tc_q != 2'd3) tc_d = tc_q + 2'd1;
            phase_d = PH_TAPHELD;
          end
        end
        PH_IDLE: begin
        end
        default: begin
        end
      endcase
    end

    // Storing a character: the length limit wins over the end key.
    if (do_store) begin
      if (nc >= {1'b0, cfg_i.max_length}) begin
        ch_v   = 1'b1;
        sc_d   = nc[7:0];
        end_v  = 1'b1;
        end_st = ST_LENGTH;
      end else if (hc_q == cfg_i.end_code) begin
        end_v  = 1'b1;
        end_st = ST_OK;
      end else begin
        ch_v    = 1'b1;
        sc_d    = nc[7:0];
        do_wait = 1'b1;
      end
    end

    if (do_wait) begin
      phase_d = PH_WAIT;
      secs_d  = cfg_i.timeout_seconds;
      if (cfg_i.timeout_seconds == 8'd0) begin
        end_v  = 1'b1;
        end_st = ST_TIMEOUT;
      end else if (on_hook_i) begin
        end_v  = 1'b1;
        end_st = ST_HOOK;
      end
    end

    if (end_v) begin
      phase_d = PH_IDLE;
      secs_d  = 8'd0;
      tt_d    = 4'd0;
      tc_d    = 2'd0;
    end
  end

  always_comb begin
    res_t chr;
    res_t fin;

    chr.kind       = KIND_CHAR;
    chr.char_value = held_char;
    chr.position   = ch_pos;
    chr.status     = ST_OK;
    chr.last       = ~end_v;
    fin.kind       = KIND_END;
    fin.char_value = 8'd0;
    fin.position   = sc_d;
    fin.status     = end_st;
    fin.last       = 1'b1;

    push_o.count  = accept_i ? ({1'b0, ch_v} + {1'b0, end_v}) : 2'd0;
    push_o.first  = ch_v ? chr : fin;
    push_o.second = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      secs_q  <= 8'd0;
      tt_q    <= 4'd0;
      tc_q    <= 2'd0;
      hc_q    <= 4'd0;
      sc_q    <= 8'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      secs_q  <= secs_d;
      tt_q    <= tt_d;
      tc_q    <= tc_d;
      hc_q    <= hc_d;
      sc_q    <= sc_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dkec_res_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module dkec_res_fifo
  import dkec_pkg::*;
#(
  parameter int unsigned Depth = ResDepthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       room2_o,
  output logic       valid_o,
  output res_t       data_o,
  input  wire logic  pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q, wr1, wr2, rd1;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr1     = wrap_inc(wr_q);
  assign wr2     = wrap_inc(wr1);
  assign rd1     = wrap_inc(rd_q);
  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i & valid_o;
  assign room2_o = (cnt_q <= CntW'(Depth - 2));
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr1] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      case (push_i.count)
        2'd1:    wr_q <= wr1;
        2'd2:    wr_q <= wr2;
        default: wr_q <= wr_q;
      endcase
      if (pop) rd_q <= rd1;
      cnt_q <= cnt_q + CntW'(push_i.count) - CntW'(pop);
    end
  end

endmodule

`default_nettype wire

[rtl/core/dtmf_key_entry_collector_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Key entry collector for a 4-bit DTMF decoder.
// Input stream: one word per event. s_axis_tuser carries the event (start,
// key press, key release, second tick, tenth-second tick); s_axis_tdata
// carries the key code and the hook level. Each word is folded into the
// session state in the cycle it is accepted, so a word can be taken every
// cycle while the result queue has room for two records.
// Output stream: zero, one or two records per input word, in order. A
// character record comes before an end-of-line record; m_axis_tlast marks
// the last record caused by one input word, m_axis_tuser tells a character
// record from an end record. A word's records are written into the queue
// as it is accepted and leave at one per cycle while m_axis_tready is high.
// Throughput is set by the result queue drain: one record per cycle, so a
// steady stream of one-record words runs at one word per cycle.
// When the receiver stalls, records wait in the queue (ResDepth deep) and
// s_axis_tready drops once fewer than two slots are free. Reset clears the
// session to idle, empties the queue and loads the register defaults:
// digit-table mode, length 16, end code 12, timeout 10 s, tap delay four tenth
// ticks. Registers must be written on cfg_we_i only while idle (not enforced).

module dtmf_key_entry_collector_unit
  import dkec_pkg::*;
#(
  parameter int unsigned ResDepth = ResDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,

  // Event input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [3:0] key_code, [4] on_hook, [7:5] zero
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] event code

  // Result record stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] char_value, [15:8] position,
                                           // [17:16] status, [23:18] zero
  output logic             m_axis_tuser,   // [0] kind
  output logic             m_axis_tlast    // last record of one input word
);

  cfg_t  cfg_q;
  push_t push;
  res_t  head;
  logic  room2;
  logic  accept;

  // Register file. Writes to indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_mode      <= MODE_DIGIT;
      cfg_q.max_length      <= 8'd16;
      cfg_q.end_code        <= 4'd12;
      cfg_q.timeout_seconds <= 8'd10;
      cfg_q.tap_delay_ticks <= 4'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENTRY_MODE:  cfg_q.entry_mode      <= cfg_data_i[1:0];
        CFG_MAX_LENGTH:  cfg_q.max_length      <= cfg_data_i;
        CFG_END_CODE:    cfg_q.end_code        <= cfg_data_i[3:0];
        CFG_TIMEOUT_SEC: cfg_q.timeout_seconds <= cfg_data_i;
        CFG_TAP_DELAY:   cfg_q.tap_delay_ticks <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // A word is taken only while the queue can absorb the worst case of two
  // records, so no record is ever dropped.
  assign s_axis_tready = room2;
  assign accept        = s_axis_tvalid & room2;

  dkec_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .ev_i       (s_axis_tuser),
    .key_code_i (s_axis_tdata[3:0]),
    .on_hook_i  (s_axis_tdata[4]),
    .push_o     (push)
  );

  dkec_res_fifo #(
    .Depth (ResDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .valid_o (m_axis_tvalid),
    .data_o  (head),
    .pop_i   (m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, head.status, head.position, head.char_value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

[tb/tb_dtmf_key_entry_collector_unit.sv]
`timescale 1ns / 1ps

module tb_dtmf_key_entry_collector_unit;
  import dkec_pkg::*;

  // The run is stopped here even if the block hangs. This is far more than the
  // slowest correct run needs, with every gap and stall at its longest.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles to let pass once the last expected record has arrived. This covers
  // words that are still in flight and cause no record.
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  // Event codes 5 to 7 are not assigned. The block must ignore them in
  // every phase.
  localparam logic [2:0] EV_SPARE_FIRST = 3'd5;
  localparam logic [2:0] EV_SPARE_LAST  = 3'd7;

  localparam logic [7:0] DASH_CHAR = 8'h2D;
  // Digit table, with key code 0 as the leftmost character.
  localparam logic [13*8-1:0] DIGIT_CHARS = "-1234567890*#";
  // Multi-tap table, four characters per key code. Entry 5 is the n with tilde.
  localparam logic [52*8-1:0] TAP_CHARS =
    {"----q", 8'hF1, "z1abc2def3ghi4jkl5mno6prs7tuv8wxy9 -_0*.,:####"};

  typedef enum logic [2:0] {
    LINE_IDLE,
    LINE_WAIT,
    KEY_DOWN,
    TAP_DOWN,
    TAP_SETTLE
  } line_phase_e;

  // Line entry predictor and record scoreboard. It keeps its own copy of the
  // registers and the session state, turns every accepted input word into the
  // records it should cause, and checks the records that leave the block
  // against them in order.
  class entry_line_model;
    entry_mode_e  entry_mode;
    logic [7:0]   max_length;
    logic [3:0]   end_code;
    logic [7:0]   timeout_sec;
    logic [3:0]   tap_delay;

    line_phase_e  phase;
    logic [7:0]   seconds_left;
    logic [3:0]   tap_ticks_left;
    logic [1:0]   tap_count;
    logic [3:0]   held_code;
    logic [7:0]   stored_count;

    res_t         pending_records[$];
    res_t         step_out[2];
    int           step_n;

    int           mismatches;
    int           char_records;
    int           end_by_status[4];

    function new();
      entry_mode     = MODE_DIGIT;
      max_length     = 8'd16;
      end_code       = 4'd12;
      timeout_sec    = 8'd10;
      tap_delay      = 4'd4;
      phase          = LINE_IDLE;
      seconds_left   = '0;
      tap_ticks_left = '0;
      tap_count      = '0;
      held_code      = '0;
      stored_count   = '0;
      mismatches     = 0;
      char_records   = 0;
      foreach (end_by_status[i]) end_by_status[i] = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [7:0] value);
      case (idx)
        CFG_ENTRY_MODE:  entry_mode  = entry_mode_e'(value[1:0]);
        CFG_MAX_LENGTH:  max_length  = value;
        CFG_END_CODE:    end_code    = value[3:0];
        CFG_TIMEOUT_SEC: timeout_sec = value;
        CFG_TAP_DELAY:   tap_delay   = value[3:0];
        default: ;
      endcase
    endfunction

    function void emit(logic kind, logic [7:0] ch, logic [7:0] pos, logic [1:0] st);
      res_t r;
      r.kind       = kind;
      r.char_value = ch;
      r.position   = pos;
      r.status     = st;
      r.last       = 1'b0;
      step_out[step_n] = r;
      step_n++;
    endfunction

    function void end_line(end_status_e st);
      emit(KIND_END, 8'h00, stored_count, st);
      phase          = LINE_IDLE;
      seconds_left   = '0;
      tap_ticks_left = '0;
      tap_count      = '0;
    endfunction

    // Entering the wait for a key runs the timeout check first, then hook.
    function void begin_wait(logic hook);
      phase        = LINE_WAIT;
      seconds_left = timeout_sec;
      if (seconds_left == 0) end_line(ST_TIMEOUT);
      else if (hook) end_line(ST_HOOK);
    endfunction

    // The length limit wins over the end key: the character is stored even
    // when it is the end key.
    function void store_char(logic [7:0] ch, logic hook);
      logic [8:0] next_count;
      next_count = {1'b0, stored_count} + 9'd1;
      if (next_count >= {1'b0, max_length}) begin
        emit(KIND_CHAR, ch, stored_count, ST_OK);
        stored_count = next_count[7:0];
        end_line(ST_LENGTH);
      end else if (held_code == end_code) begin
        end_line(ST_OK);
      end else begin
        emit(KIND_CHAR, ch, stored_count, ST_OK);
        stored_count = next_count[7:0];
        begin_wait(hook);
      end
    endfunction

    function logic [7:0] held_char();
      int idx;
      if (held_code == end_code || entry_mode == MODE_RAW || entry_mode == MODE_ALT) begin
        return {4'd0, held_code};
      end
      if (held_code > 4'd12) return DASH_CHAR;
      if (entry_mode == MODE_DIGIT) begin
        idx = int'(held_code);
        return DIGIT_CHARS[(12 - idx) * 8 +: 8];
      end
      idx = int'(held_code) * 4 + int'(tap_count);
      return TAP_CHARS[(51 - idx) * 8 +: 8];
    endfunction

    function void note_event(logic [2:0] ev, logic [3:0] code, logic hook);
      step_n = 0;
      if (ev == EV_START) begin
        // A start throws away any session in progress.
        stored_count   = '0;
        tap_count      = '0;
        tap_ticks_left = '0;
        held_code      = '0;
        begin_wait(hook);
      end else if (ev <= EV_TENTH) begin
        case (phase)
          LINE_WAIT: begin
            if (ev == EV_SECOND && seconds_left > 0) seconds_left = seconds_left - 8'd1;
            if (seconds_left == 0) end_line(ST_TIMEOUT);
            else if (hook) end_line(ST_HOOK);
            else if (ev == EV_PRESS) begin
              held_code = code;
              tap_count = '0;
              phase     = (entry_mode == MODE_TAP) ? TAP_DOWN : KEY_DOWN;
            end
          end
          KEY_DOWN: begin
            // Hanging up with a key held counts as releasing it.
            if (ev == EV_RELEASE || hook) store_char(held_char(), hook);
          end
          TAP_DOWN: begin
            if (ev == EV_RELEASE || hook) begin
              if (tap_delay == 0) store_char(held_char(), hook);
              else begin
                phase          = TAP_SETTLE;
                tap_ticks_left = tap_delay;
              end
            end
          end
          TAP_SETTLE: begin
            // Hook is not looked at here; the wait check after the letter
            // settles sees it.
            if (ev == EV_TENTH) begin
              if (tap_ticks_left > 0) tap_ticks_left = tap_ticks_left - 4'd1;
              if (tap_ticks_left == 0) store_char(held_char(), hook);
            end else if (ev == EV_PRESS) begin
              if (tap_count < 2'd3) tap_count = tap_count + 2'd1;
              phase = TAP_DOWN;
            end
          end
          default: ;
        endcase
      end
      for (int i = 0; i < step_n; i++) begin
        if (i == step_n - 1) step_out[i].last = 1'b1;
        pending_records.push_back(step_out[i]);
      end
    endfunction

    function void note_mismatch(string what, res_t want, res_t got);
      if (mismatches < REPORT_LIMIT) begin
        $display("%0t: %s: expected kind %0d char %02h pos %0d status %0d last %0d,",
                 $time, what, want.kind, want.char_value, want.position, want.status,
                 want.last);
        $display("    got kind %0d char %02h pos %0d status %0d last %0d",
                 got.kind, got.char_value, got.position, got.status, got.last);
      end
      mismatches++;
    endfunction

    function void check_record(logic kind, logic [23:0] data, logic last_flag);
      res_t want;
      res_t got;
      got.kind       = kind;
      got.char_value = data[7:0];
      got.position   = data[15:8];
      got.status     = data[17:16];
      got.last       = last_flag;
      if (pending_records.size() == 0) begin
        note_mismatch("record with nothing pending", '0, got);
        return;
      end
      want = pending_records.pop_front();
      if (got.kind !== want.kind || got.char_value !== want.char_value ||
          got.position !== want.position || got.status !== want.status ||
          got.last !== want.last) begin
        note_mismatch("record mismatch", want, got);
      end
      if (want.kind == KIND_END) end_by_status[want.status]++;
      else char_records++;
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_index_i   = CFG_ENTRY_MODE;
  logic [7:0]  cfg_data_i    = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [3:0] key_code, [4] on_hook, [7:5] zero
  logic [2:0]  s_axis_tuser  = EV_START;  // [2:0] event code
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // [7:0] char_value, [15:8] position, [17:16] status
  logic        m_axis_tuser;  // [0] kind
  logic        m_axis_tlast;

  entry_line_model board;

  // Idling on both sides is switched on and off in stretches by the stimulus.
  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int settings_run = 0;

  dtmf_key_entry_collector_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver stalls in random bursts. Ready changes only
  // at the falling edge, so the block sees a stable level at every rising one.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // A record is taken at every rising edge where valid and ready are both high.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_record(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  // Offers one event word and waits until it is accepted. A random gap with
  // valid low may come first. Valid stays high between back-to-back words,
  // so it is never lowered and raised in the same time step.
  task automatic send_event(input logic [2:0] ev, input logic [3:0] code, input logic hook);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev;
    s_axis_tdata  <= {3'b000, hook, code};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_event(ev, code, hook);
    words_sent++;
  endtask

  // Stops offering words and waits until every expected record has left the
  // block, then lets the settle margin pass for words that cause no record.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A start word with the hook up always closes the session, either with the
  // hook status or, when the timeout is zero, at once with timeout.
  task automatic end_session();
    if (board.phase != LINE_IDLE) send_event(EV_START, 4'd0, 1'b1);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // Registers are only written with no session open and the block drained.
  task automatic configure(input entry_mode_e mode, input logic [7:0] max_len,
                           input logic [3:0] end_key, input logic [7:0] timeout,
                           input logic [3:0] tap_ticks);
    end_session();
    drain();
    write_reg(CFG_ENTRY_MODE, {6'd0, mode});
    write_reg(CFG_MAX_LENGTH, max_len);
    write_reg(CFG_END_CODE, {4'd0, end_key});
    write_reg(CFG_TIMEOUT_SEC, timeout);
    write_reg(CFG_TAP_DELAY, {4'd0, tap_ticks});
    settings_run++;
  endtask

  // Random event words, picked from the predicted phase so that most words
  // follow a plausible key sequence: presses while waiting, releases while a
  // key is down, tenth ticks while a letter settles. The rest is ticks, hook,
  // stray starts and unassigned event codes. Words sent while no session is
  // open, other than starts, are ignored by the block and are not counted.
  task automatic random_words(input int word_total, input bit allow_idle);
    int done;
    int roll;
    logic [2:0] ev;
    logic [3:0] code;
    logic hook;
    done = 0;
    idle_on = allow_idle;
    while (done < word_total) begin
      roll = $urandom_range(0, 99);
      code = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) code = board.end_code;
      hook = ($urandom_range(0, 39) == 0);
      case (board.phase)
        LINE_IDLE: begin
          ev = (roll < 85) ? EV_START : 3'($urandom_range(EV_PRESS, EV_SPARE_LAST));
        end
        LINE_WAIT: begin
          ev = (roll < 70) ? EV_PRESS : (roll < 85) ? EV_SECOND : (roll < 92) ? EV_TENTH :
               (roll < 95) ? EV_RELEASE : (roll < 97) ? EV_START :
               3'($urandom_range(EV_SPARE_FIRST, EV_SPARE_LAST));
        end
        KEY_DOWN, TAP_DOWN: begin
          ev = (roll < 75) ? EV_RELEASE : (roll < 85) ? EV_TENTH : (roll < 92) ? EV_SECOND :
               (roll < 95) ? EV_PRESS : (roll < 97) ? EV_START :
               3'($urandom_range(EV_SPARE_FIRST, EV_SPARE_LAST));
        end
        default: begin
          ev = (roll < 60) ? EV_TENTH : (roll < 85) ? EV_PRESS : (roll < 92) ? EV_SECOND :
               (roll < 95) ? EV_RELEASE : (roll < 97) ? EV_START :
               3'($urandom_range(EV_SPARE_FIRST, EV_SPARE_LAST));
        end
      endcase
      if (board.phase != LINE_IDLE || ev == EV_START) done++;
      send_event(ev, code, hook);
      // Stretches with and without idling alternate.
      if (allow_idle && $urandom_range(0, 79) == 0) idle_on = ($urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset settings: digit table, length 16,
    // end key 12, timeout 10 s, tap delay four tenth ticks.
    send_event(EV_PRESS, 4'd3, 1'b0);         // no session yet, ignored
    send_event(EV_SPARE_LAST, 4'd15, 1'b1);   // unassigned event while idle
    send_event(EV_START, 4'd0, 1'b0);
    send_event(EV_SPARE_FIRST, 4'd0, 1'b0);   // unassigned event while waiting
    send_event(EV_TENTH, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd15, 1'b0);        // code above the table
    send_event(EV_RELEASE, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd0, 1'b0);
    send_event(EV_RELEASE, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd12, 1'b0);        // end key closes the line
    send_event(EV_RELEASE, 4'd0, 1'b0);
    send_event(EV_START, 4'd0, 1'b1);         // start with the hook up
    send_event(EV_START, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd7, 1'b0);
    send_event(EV_START, 4'd0, 1'b0);         // restart drops the held key
    send_event(EV_PRESS, 4'd4, 1'b0);
    send_event(EV_SECOND, 4'd0, 1'b1);        // hang up with a key held

    // Multi-tap letters with a short timeout and delay.
    configure(MODE_TAP, 8'd3, 4'd11, 8'd2, 4'd2);
    send_event(EV_START, 4'd0, 1'b0);
    send_event(EV_SECOND, 4'd0, 1'b0);
    send_event(EV_SECOND, 4'd0, 1'b0);        // timeout between keys
    send_event(EV_START, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd2, 1'b0);
    send_event(EV_RELEASE, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd9, 1'b0);         // another key still advances the tap
    send_event(EV_RELEASE, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd2, 1'b0);
    send_event(EV_RELEASE, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd2, 1'b0);
    send_event(EV_RELEASE, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd5, 1'b0);         // tap count already saturated
    send_event(EV_SECOND, 4'd0, 1'b1);        // hook acts as the release
    send_event(EV_RELEASE, 4'd0, 1'b1);       // hook ignored while settling
    send_event(EV_TENTH, 4'd0, 1'b1);
    send_event(EV_TENTH, 4'd0, 1'b1);         // letter settles, then hook ends

    // Zero length limit with raw codes: the end key itself is stored.
    configure(MODE_ALT, 8'd0, 4'd12, 8'd255, 4'd0);
    send_event(EV_START, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd12, 1'b0);
    send_event(EV_RELEASE, 4'd0, 1'b0);

    // Zero tap delay settles at the release; the second letter hits the limit.
    configure(MODE_TAP, 8'd2, 4'd12, 8'd1, 4'd0);
    send_event(EV_START, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd6, 1'b0);
    send_event(EV_RELEASE, 4'd0, 1'b0);
    send_event(EV_PRESS, 4'd14, 1'b0);
    send_event(EV_RELEASE, 4'd0, 1'b0);

    // A zero timeout closes the session on the start word.
    configure(MODE_RAW, 8'd16, 4'd0, 8'd0, 4'd4);
    send_event(EV_START, 4'd0, 1'b0);

    // Random part over several settings, extremes among them. The last one
    // runs with no idling on either side.
    configure(MODE_TAP, 8'd20, 4'd12, 8'd10, 4'd4);
    random_words(300, 1'b1);
    configure(MODE_RAW, 8'd255, 4'd15, 8'd255, 4'd15);
    random_words(200, 1'b1);
    configure(MODE_TAP, 8'd1, 4'd0, 8'd1, 4'd1);
    random_words(150, 1'b1);
    configure(MODE_DIGIT, 8'd8, 4'd5, 8'd3, 4'd0);
    random_words(200, 1'b1);
    configure(MODE_ALT, 8'd4, 4'd13, 8'd0, 4'd2);
    random_words(60, 1'b1);
    configure(MODE_TAP, 8'd6, 4'd12, 8'd5, 4'd15);
    random_words(250, 1'b1);
    configure(MODE_DIGIT, 8'd12, 4'd12, 8'd6, 4'd3);
    random_words(200, 1'b1);
    configure(MODE_TAP, 8'd10, 4'd11, 8'd4, 4'd2);
    random_words(240, 1'b0);

    end_session();
    drain();

    if (board.pending_records.size() != 0) begin
      $display("%0d expected records never arrived", board.pending_records.size());
    end
    $display("Sent %0d event words over %0d register settings; %0d character records.",
             words_sent, settings_run, board.char_records);
    $display("Lines closed: %0d ok, %0d timeout, %0d hook, %0d length; %0d mismatches.",
             board.end_by_status[ST_OK], board.end_by_status[ST_TIMEOUT],
             board.end_by_status[ST_HOOK], board.end_by_status[ST_LENGTH],
             board.mismatches);
    if (board.mismatches == 0 && board.pending_records.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
